@@ design/qct_pkg.sv @@
package qct_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned CountW = 11;

  localparam logic [CountW-1:0] ArgLimit     = CountW'(1024);
  localparam logic [CountW-1:0] MaxArgsReset = CountW'(1024);

  localparam logic [ByteW-1:0] ChSpace  = 8'h20;
  localparam logic [ByteW-1:0] ChTab    = 8'h09;
  localparam logic [ByteW-1:0] ChCr     = 8'h0d;
  localparam logic [ByteW-1:0] ChSemi   = 8'h3b;
  localparam logic [ByteW-1:0] ChBslash = 8'h5c;
  localparam logic [ByteW-1:0] ChDquote = 8'h22;
  localparam logic [ByteW-1:0] ChSquote = 8'h27;
  localparam logic [ByteW-1:0] ChNul    = 8'h00;

  typedef enum logic [2:0] {
    StOk      = 3'd0,
    StOpenEsc = 3'd1,
    StOpenDq  = 3'd2,
    StOpenSq  = 3'd3,
    StTooMany = 3'd4
  } status_e;

  typedef struct packed {
    logic              byte_valid;
    logic [ByteW-1:0]  out_byte;
    logic              token_done;
    logic              command_done;
    logic [CountW-1:0] arg_count;
    status_e           status;
  } result_t;

  function automatic logic is_ws(input logic [ByteW-1:0] c);
    is_ws = (c == ChSpace) || ((c >= ChTab) && (c <= ChCr));
  endfunction

endpackage

@@ design/qct_core.sv @@
module qct_core import qct_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [CountW-1:0] cfg_wdata_i,
  input  logic              step_i,
  input  logic [ByteW-1:0]  in_byte_i,
  input  logic              line_end_i,
  output result_t           res_o
);

  logic              esc_q, esc_d;
  logic              dq_q, dq_d;
  logic              sq_q, sq_d;
  logic              tok_q, tok_d;
  logic              disc_q, disc_d;
  logic [CountW-1:0] args_q, args_d;
  logic [CountW-1:0] max_args_q;
  logic [CountW-1:0] limit;
  logic [CountW-1:0] n_inc;
  result_t           close_res;
  result_t           res;

  assign limit = (max_args_q > ArgLimit) ? ArgLimit : max_args_q;
  assign n_inc = args_q + CountW'(1);

  // result of closing the line content
  always_comb begin
    close_res = '0;
    close_res.status = StOk;
    if (tok_q) begin
      if (esc_q) begin
        close_res.arg_count = args_q;
        close_res.status    = StOpenEsc;
      end else if (dq_q) begin
        close_res.arg_count = args_q;
        close_res.status    = StOpenDq;
      end else if (sq_q) begin
        close_res.arg_count = args_q;
        close_res.status    = StOpenSq;
      end else if (n_inc > limit) begin
        close_res.arg_count = n_inc;
        close_res.status    = StTooMany;
      end else begin
        close_res.arg_count    = n_inc;
        close_res.token_done   = 1'b1;
        close_res.command_done = 1'b1;
      end
    end else begin
      close_res.arg_count    = args_q;
      close_res.command_done = (args_q != '0);
    end
  end

  always_comb begin
    res        = '0;
    res.status = StOk;
    esc_d      = esc_q;
    dq_d       = dq_q;
    sq_d       = sq_q;
    tok_d      = tok_q;
    disc_d     = disc_q;
    args_d     = args_q;
    if (line_end_i || (!disc_q && in_byte_i == ChNul)) begin
      if (!disc_q) begin
        res = close_res;
      end
      esc_d  = 1'b0;
      dq_d   = 1'b0;
      sq_d   = 1'b0;
      tok_d  = 1'b0;
      args_d = '0;
      disc_d = !line_end_i;
    end else if (disc_q) begin
      res = '0;
    end else if (!tok_q && is_ws(in_byte_i)) begin
      res.arg_count = args_q;
    end else if (!tok_q && in_byte_i == ChSemi) begin
      res.token_done   = 1'b1;
      res.command_done = 1'b1;
      res.arg_count    = n_inc;
      args_d           = '0;
    end else begin
      tok_d         = 1'b1;
      res.arg_count = args_q;
      if (esc_q) begin
        esc_d          = 1'b0;
        res.byte_valid = 1'b1;
        res.out_byte   = in_byte_i;
      end else if (in_byte_i == ChBslash) begin
        esc_d = 1'b1;
      end else if (in_byte_i == ChDquote && !sq_q) begin
        dq_d = ~dq_q;
      end else if (in_byte_i == ChSquote && !dq_q) begin
        sq_d = ~sq_q;
      end else if (!dq_q && !sq_q && is_ws(in_byte_i)) begin
        tok_d         = 1'b0;
        res.arg_count = n_inc;
        if (n_inc > limit) begin
          res.status = StTooMany;
          esc_d      = 1'b0;
          args_d     = '0;
          disc_d     = 1'b1;
        end else begin
          res.token_done = 1'b1;
          args_d         = n_inc;
        end
      end else if (!dq_q && !sq_q && in_byte_i == ChSemi) begin
        tok_d            = 1'b0;
        res.token_done   = 1'b1;
        res.command_done = 1'b1;
        res.arg_count    = n_inc;
        args_d           = '0;
      end else begin
        res.byte_valid = 1'b1;
        res.out_byte   = in_byte_i;
      end
    end
  end

  assign res_o = res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      esc_q      <= 1'b0;
      dq_q       <= 1'b0;
      sq_q       <= 1'b0;
      tok_q      <= 1'b0;
      disc_q     <= 1'b0;
      args_q     <= '0;
      max_args_q <= MaxArgsReset;
    end else begin
      if (cfg_we_i) begin
        max_args_q <= cfg_wdata_i;
      end
      if (step_i) begin
        esc_q  <= esc_d;
        dq_q   <= dq_d;
        sq_q   <= sq_d;
        tok_q  <= tok_d;
        disc_q <= disc_d;
        args_q <= args_d;
      end
    end
  end

endmodule

@@ design/quoted_command_tokenizer_top.sv @@
// Command line tokenizer.
// Slave side: one beat per character, s_axis_tdata = the byte, s_axis_tlast
// marks the line end (the byte is then ignored). Master side: exactly one
// beat per input beat, in order. m_axis_tdata carries byte_valid, the
// unquoted character, token_done, arg_count and status; m_axis_tlast is
// command_done (a command with at least one argument ended).
// cfg_we_i / cfg_wdata_i load max_args (reset 1024); write only when idle.
// The input register loads on the edge that takes a beat, the result register
// and m_axis_tvalid when that beat advances, which waits while a result is
// stalled. Throughput: one beat per cycle while the receiver is not stalling,
// set by the combinational tokenizer step between the registers.
// Reset clears all line state and both pipeline valid flags, and loads max_args.
// When the receiver stalls the result holds, the input register keeps one
// more beat, and s_axis_tready falls until the result is taken.
module quoted_command_tokenizer_top import qct_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [CountW-1:0] cfg_wdata_i,
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic [7:0]        s_axis_tdata,  // in_byte
  input  logic              s_axis_tlast,  // line_end
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  // byte_valid, out_byte[8:1], token_done, arg_count[20:10], status[23:21]
  output logic [23:0]       m_axis_tdata,
  output logic              m_axis_tlast   // command_done
);

  logic             in_valid_q;
  logic [ByteW-1:0] in_byte_q;
  logic             in_last_q;
  logic             out_valid_q;
  result_t          out_q;
  result_t          res;
  logic             advance;

  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;

  qct_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .step_i      (advance),
    .in_byte_i   (in_byte_q),
    .line_end_i  (in_last_q),
    .res_o       (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s_axis_tready) begin
        in_valid_q <= s_axis_tvalid;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_byte_q <= s_axis_tdata;
      in_last_q <= s_axis_tlast;
    end
    if (advance) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {out_q.status, out_q.arg_count, out_q.token_done,
                          out_q.out_byte, out_q.byte_valid};
  assign m_axis_tlast  = out_q.command_done;

endmodule

@@ design/qct_checker.sv @@
module qct_checker import qct_pkg::*; (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              s_axis_tready,
  input logic              m_axis_tvalid,
  input logic              m_axis_tready,
  input logic [23:0]       m_axis_tdata,
  input logic              m_axis_tlast
);

  // stalled beat holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("stalled result changed");

  // input side only backs up behind a stalled result
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
    else $error("input not ready without a stalled result");

  a_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[23:21] <= StTooMany)
    else $error("bad status code");

  a_char: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[0] |->
      !m_axis_tdata[9] && !m_axis_tlast && m_axis_tdata[23:21] == StOk)
    else $error("character beat also ends token or reports error");

  a_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tlast |->
      m_axis_tdata[23:21] == StOk && m_axis_tdata[20:10] != '0)
    else $error("command end without arguments or with error");

endmodule

bind quoted_command_tokenizer_top qct_checker u_qct_checker (.*);

@@ bench/testbench.sv @@
module testbench;
  import qct_pkg::*;

  localparam int unsigned RandomItems = 1150;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              cfg_we_i = 1'b0;
  logic [CountW-1:0] cfg_wdata_i = '0;
  logic              s_axis_tvalid = 1'b0;
  logic              s_axis_tready;
  logic [7:0]        s_axis_tdata = '0;  // in_byte
  logic              s_axis_tlast = 1'b0;  // line_end
  logic              m_axis_tvalid;
  logic              m_axis_tready = 1'b0;
  // byte_valid, out_byte[8:1], token_done, arg_count[20:10], status[23:21]
  logic [23:0]       m_axis_tdata;
  logic              m_axis_tlast;  // command_done

  quoted_command_tokenizer_top u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // tokenizer state as predicted
  logic              p_esc, p_dq, p_sq, p_in_tok, p_drop;
  logic [CountW-1:0] p_args;
  logic [CountW-1:0] p_max_args = MaxArgsReset;
  result_t           tok_results_q[$];

  int unsigned n_items, n_checked, n_flagged, n_cfg, n_fail, burst_left;
  int unsigned rx_mode;

  function automatic result_t mk_res(logic bv, logic [7:0] b, logic td, logic cd,
                                     int unsigned cnt, status_e st);
    result_t r;
    r.byte_valid   = bv;
    r.out_byte     = b;
    r.token_done   = td;
    r.command_done = cd;
    r.arg_count    = (cnt > 2047) ? CountW'(2047) : CountW'(cnt);
    r.status       = st;
    return r;
  endfunction

  function automatic logic ws_char(logic [7:0] c);
    return (c == ChSpace) || ((c >= ChTab) && (c <= ChCr));
  endfunction

  function automatic logic [CountW-1:0] arg_cap();
    return (p_max_args > ArgLimit) ? ArgLimit : p_max_args;
  endfunction

  task automatic clear_line_state();
    p_esc    = 1'b0;
    p_dq     = 1'b0;
    p_sq     = 1'b0;
    p_in_tok = 1'b0;
    p_args   = '0;
    p_drop   = 1'b0;
  endtask

  task automatic close_line_res(output result_t r);
    int unsigned n;
    status_e     st;
    n = p_args + 1;
    if (p_in_tok) begin
      if (p_esc) st = StOpenEsc;
      else if (p_dq) st = StOpenDq;
      else if (p_sq) st = StOpenSq;
      else st = StOk;
      if (st != StOk) r = mk_res(0, 0, 0, 0, p_args, st);
      else if (n > arg_cap()) r = mk_res(0, 0, 0, 0, n, StTooMany);
      else r = mk_res(0, 0, 1, 1, n, StOk);
    end else begin
      r = mk_res(0, 0, 0, p_args != 0, p_args, StOk);
    end
    clear_line_state();
  endtask

  task automatic tokenize_step(input logic [7:0] b, input logic le);
    result_t     r;
    int unsigned n;
    n = p_args + 1;
    if (le) begin
      if (p_drop) begin
        r = mk_res(0, 0, 0, 0, 0, StOk);
        clear_line_state();
      end else begin
        close_line_res(r);
      end
    end else if (p_drop) begin
      r = mk_res(0, 0, 0, 0, 0, StOk);
    end else if (b == ChNul) begin
      close_line_res(r);
      p_drop = 1'b1;
    end else if (!p_in_tok && ws_char(b)) begin
      r = mk_res(0, 0, 0, 0, p_args, StOk);
    end else if (!p_in_tok && b == ChSemi) begin
      r = mk_res(0, 0, 1, 1, n, StOk);
      p_args = '0;
    end else begin
      p_in_tok = 1'b1;
      if (p_esc) begin
        p_esc = 1'b0;
        r = mk_res(1, b, 0, 0, p_args, StOk);
      end else if (b == ChBslash) begin
        p_esc = 1'b1;
        r = mk_res(0, 0, 0, 0, p_args, StOk);
      end else if (b == ChDquote && !p_sq) begin
        p_dq = ~p_dq;
        r = mk_res(0, 0, 0, 0, p_args, StOk);
      end else if (b == ChSquote && !p_dq) begin
        p_sq = ~p_sq;
        r = mk_res(0, 0, 0, 0, p_args, StOk);
      end else if (!p_dq && !p_sq && ws_char(b)) begin
        p_in_tok = 1'b0;
        if (n > arg_cap()) begin
          r = mk_res(0, 0, 0, 0, n, StTooMany);
          clear_line_state();
          p_drop = 1'b1;
        end else begin
          p_args = CountW'(n);
          r = mk_res(0, 0, 1, 0, n, StOk);
        end
      end else if (!p_dq && !p_sq && b == ChSemi) begin
        p_in_tok = 1'b0;
        r = mk_res(0, 0, 1, 1, n, StOk);
        p_args = '0;
      end else begin
        r = mk_res(1, b, 0, 0, p_args, StOk);
      end
    end
    if (r.status != StOk) n_flagged++;
    tok_results_q.push_back(r);
  endtask

  // called at a rising edge; returns at the edge that took the beat (or after the gap)
  task automatic send_beat(input logic [7:0] b, input logic le);
    int unsigned gap;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tlast  <= le;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    tokenize_step(b, le);
    n_items++;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end else begin
      burst_left--;
    end
  endtask

  task automatic send_str(input string s);
    for (int i = 0; i < s.len(); i++) send_beat(s[i], 1'b0);
  endtask

  task automatic end_line();
    send_beat(8'($urandom_range(0, 255)), 1'b1);
  endtask

  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (tok_results_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_max_args(input logic [CountW-1:0] v);
    wait_idle();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    p_max_args = v;
    cfg_we_i <= 1'b0;
    n_cfg++;
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      n_fail++;
    end
  endtask

  always @(posedge clk_i) begin : result_check
    result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (tok_results_q.size() == 0) begin
        $error("result beat %h with nothing expected", m_axis_tdata);
        n_fail++;
      end else begin
        want = tok_results_q.pop_front();
        check_field("byte_valid", want.byte_valid, m_axis_tdata[0]);
        check_field("out_byte", want.out_byte, m_axis_tdata[8:1]);
        check_field("token_done", want.token_done, m_axis_tdata[9]);
        check_field("command_done", want.command_done, m_axis_tlast);
        check_field("arg_count", want.arg_count, m_axis_tdata[20:10]);
        check_field("status", want.status, m_axis_tdata[23:21]);
        n_checked++;
      end
    end
  end

  // receiver: always ready, coin flip, or mostly stalled
  always @(posedge clk_i) begin
    if ($urandom_range(0, 99) == 0) rx_mode = $urandom_range(0, 2);
    case (rx_mode)
      0: m_axis_tready <= 1'b1;
      1: m_axis_tready <= 1'($urandom_range(0, 1));
      default: m_axis_tready <= ($urandom_range(0, 5) == 0);
    endcase
  end

  function automatic logic [7:0] plain_char();
    if ($urandom_range(0, 3) == 0) return 8'($urandom_range(128, 255));
    return 8'($urandom_range(97, 122));
  endfunction

  function automatic logic [7:0] ws_pick();
    if ($urandom_range(0, 1) == 0) return ChSpace;
    return 8'($urandom_range(ChTab, ChCr));
  endfunction

  function automatic logic [7:0] noise_byte();
    case ($urandom_range(0, 7))
      0, 1: return 8'($urandom_range(0, 255));
      2: return ChNul;
      3: return ChSemi;
      4: return ($urandom_range(0, 1) == 0) ? ChDquote : ChSquote;
      5: return ChBslash;
      6: return ws_pick();
      default: return plain_char();
    endcase
  endfunction

  function automatic logic [7:0] quoted_char(input logic [7:0] other_q);
    case ($urandom_range(0, 4))
      0: return ChSpace;
      1: return ChSemi;
      2: return other_q;
      default: return plain_char();
    endcase
  endfunction

  task automatic send_quoted(input logic [7:0] q, input logic [7:0] other_q);
    send_beat(q, 1'b0);
    repeat ($urandom_range(0, 3)) begin
      if ($urandom_range(0, 5) == 0) begin
        send_beat(ChBslash, 1'b0);
        send_beat(8'($urandom_range(1, 255)), 1'b0);
      end else begin
        send_beat(quoted_char(other_q), 1'b0);
      end
    end
    send_beat(q, 1'b0);
  endtask

  task automatic send_line();
    if ($urandom_range(0, 4) == 0) begin
      repeat ($urandom_range(0, 16)) send_beat(noise_byte(), 1'b0);
    end else begin
      repeat ($urandom_range(0, 6)) begin
        if ($urandom_range(0, 2) == 0) send_beat(ws_pick(), 1'b0);
        repeat ($urandom_range(1, 3)) begin
          case ($urandom_range(0, 4))
            0: begin
              send_beat(ChBslash, 1'b0);
              send_beat(8'($urandom_range(1, 255)), 1'b0);
            end
            1: send_quoted(ChDquote, ChSquote);
            2: send_quoted(ChSquote, ChDquote);
            default: send_beat(plain_char(), 1'b0);
          endcase
        end
        case ($urandom_range(0, 3))
          0: send_beat(ChSemi, 1'b0);
          1: ;
          default: send_beat(ws_pick(), 1'b0);
        endcase
      end
    end
    end_line();
  endtask

  task automatic test_plain_tokens();
    send_str("\t x\"y z\"'q\"';;");
    send_beat(8'hff, 1'b0);
    end_line();
  endtask

  task automatic test_open_quotes();
    send_str("'\\'");
    end_line();
    send_beat(ChBslash, 1'b0);
    end_line();
    send_str("\"a");
    end_line();
  endtask

  task automatic test_too_many();
    write_max_args(CountW'(1));
    send_str("a b c");
    end_line();
    write_max_args('0);
    send_str("x;x");
    end_line();
  endtask

  task automatic test_zero_byte();
    write_max_args(MaxArgsReset);
    send_beat(8'h61, 1'b0);
    send_beat(ChNul, 1'b0);
    send_beat(8'h62, 1'b0);
    end_line();
  endtask

  task automatic test_random_lines();
    int unsigned phase_start;
    logic [CountW-1:0] cap;
    phase_start = n_items;
    while (n_items < phase_start + RandomItems) begin
      if (n_items - phase_start > 0 && (n_items - phase_start) / 150 != n_cfg % 8) begin
        case ($urandom_range(0, 5))
          0: cap = CountW'(1);
          1: cap = CountW'(2047);
          2: cap = '0;
          3: cap = MaxArgsReset;
          4: cap = CountW'($urandom_range(2, 6));
          default: cap = CountW'($urandom_range(0, 2047));
        endcase
        write_max_args(cap);
      end
      send_line();
    end
  endtask

  initial begin
    clear_line_state();
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_plain_tokens();
    test_open_quotes();
    test_too_many();
    test_zero_byte();
    test_random_lines();
    wait_idle();
    $display("covered %0d characters and line ends, %0d results checked", n_items, n_checked);
    $display("%0d error statuses predicted over %0d max_args settings", n_flagged, n_cfg);
    if (n_fail == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("testbench: FAIL");
    $finish;
  end

endmodule

@@ sim.f @@
design/qct_pkg.sv
design/qct_core.sv
design/quoted_command_tokenizer_top.sv
design/qct_checker.sv
bench/testbench.sv
